// ===== hw/rtl/ptw_pkg.sv =====
package ptw_pkg;

  typedef struct packed {
    logic        opcode;
    logic [63:0] virt_addr;
    logic [63:0] table_base_override;
    logic [51:0] entry_address;
    logic [63:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] physical_address;
    logic        fault;
  } out_item_t;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  // level whose table the next read indexes
  localparam logic [1:0] LVL_PDPT = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PT   = 2'd2;

  // result kinds
  localparam logic [1:0] RES_FAULT = 2'd0;
  localparam logic [1:0] RES_1G    = 2'd1;
  localparam logic [1:0] RES_2M    = 2'd2;
  localparam logic [1:0] RES_4K    = 2'd3;

  localparam int ENTRY_PRESENT_BIT = 0;
  localparam int ENTRY_LARGE_BIT   = 7;

  typedef struct packed {
    logic       clear;       // clearing pass writes one entry
    logic       write_item;  // table entry write transaction accepted
    logic       start;       // translate accepted: read top-level entry
    logic       rd_entry;    // read next-level entry via current entry
    logic [1:0] lvl;
    logic       load_out;
    logic [1:0] res_kind;
  } ptw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic present;
    logic big_page;
    logic out_free;
  } ptw_status_t;

endpackage

// ===== hw/rtl/ptw_datapath.sv =====
module ptw_datapath
  import ptw_pkg::*;
#(
  parameter int STORE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  ptw_cmd_t    cmd,
  output ptw_status_t status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  localparam int IW = $clog2(STORE_ENTRIES);
  localparam logic [48:0] LIMIT = 49'(STORE_ENTRIES);

  logic [63:0]   mem [STORE_ENTRIES];
  logic [63:0]   rdata_r;
  logic          rd_oob_r;
  logic [IW-1:0] clr_cnt_r;
  logic [IW-1:0] clr_cnt_nxt;
  logic [63:0]   dtb_r;
  logic [38:0]   va_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  out_item_t     out_data_r;
  out_item_t     out_data_nxt;

  logic [63:0]   entry;
  logic [63:0]   base;
  logic [8:0]    lvl_idx;
  logic [44:0]   rd_idx;
  logic          rd_en;
  logic          rd_oob;
  logic [48:0]   wr_item_idx;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_data;

  assign cfg_ready = 1'b1;
  assign entry     = rd_oob_r ? 64'd0 : rdata_r;
  assign base      = (in_data.table_base_override != 64'd0) ?
                     in_data.table_base_override : dtb_r;

  always_comb begin
    case (cmd.lvl)
      LVL_PDPT: lvl_idx = va_r[38:30];
      LVL_PD:   lvl_idx = va_r[29:21];
      LVL_PT:   lvl_idx = va_r[20:12];
      default:  lvl_idx = va_r[20:12];
    endcase
  end

  // entry index = frame number : 9-bit level index
  assign rd_idx = cmd.start ? {base[47:12], in_data.virt_addr[47:39]}
                            : {entry[47:12], lvl_idx};
  assign rd_en  = cmd.start | cmd.rd_entry;
  assign rd_oob = !({4'd0, rd_idx} < LIMIT);

  assign wr_item_idx = in_data.entry_address[51:3];
  assign wr_en   = cmd.clear | (cmd.write_item & (wr_item_idx < LIMIT));
  assign wr_addr = cmd.clear ? clr_cnt_r : wr_item_idx[IW-1:0];
  assign wr_data = cmd.clear ? 64'd0 : in_data.entry_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r  <= mem[rd_idx[IW-1:0]];
      rd_oob_r <= rd_oob;
    end
    if (cmd.start) begin
      va_r <= in_data.virt_addr[38:0];
    end
  end

  assign clr_cnt_nxt = cmd.clear ? clr_cnt_r + IW'(1) : clr_cnt_r;

  always_comb begin
    case (cmd.res_kind)
      RES_1G:  out_data_nxt.physical_address = {16'd0, entry[47:30], va_r[29:0]};
      RES_2M:  out_data_nxt.physical_address = {16'd0, entry[47:21], va_r[20:0]};
      RES_4K:  out_data_nxt.physical_address = {16'd0, entry[47:12], va_r[11:0]};
      default: out_data_nxt.physical_address = 64'd0;
    endcase
    out_data_nxt.fault = (cmd.res_kind == RES_FAULT);
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      dtb_r       <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        dtb_r <= cfg_data;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.clear_last = (clr_cnt_r == IW'(STORE_ENTRIES - 1));
  assign status.present    = entry[ENTRY_PRESENT_BIT];
  assign status.big_page   = entry[ENTRY_LARGE_BIT];
  assign status.out_free   = !out_valid_r | !out_stall;

endmodule

// ===== hw/rtl/ptw_ctrl.sv =====
module ptw_ctrl
  import ptw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_opcode,
  output logic        in_stall,
  input  ptw_status_t status,
  output ptw_cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PML4  = 3'd2;  // PML4 entry in read register
  localparam logic [2:0] S_PDPT  = 3'd3;
  localparam logic [2:0] S_PD    = 3'd4;
  localparam logic [2:0] S_PT    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_WRITE) begin
            cmd.write_item = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_PML4;
          end
        end
      end
      S_PML4: begin
        if (!status.present) begin
          cmd.res_kind = RES_FAULT;
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_entry = 1'b1;
          cmd.lvl      = LVL_PDPT;
          state_nxt    = S_PDPT;
        end
      end
      S_PDPT: begin
        if (!status.present || status.big_page) begin
          cmd.res_kind = status.present ? RES_1G : RES_FAULT;
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_entry = 1'b1;
          cmd.lvl      = LVL_PD;
          state_nxt    = S_PD;
        end
      end
      S_PD: begin
        if (!status.present || status.big_page) begin
          cmd.res_kind = status.present ? RES_2M : RES_FAULT;
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          cmd.rd_entry = 1'b1;
          cmd.lvl      = LVL_PT;
          state_nxt    = S_PT;
        end
      end
      S_PT: begin
        cmd.res_kind = status.present ? RES_4K : RES_FAULT;
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/four_level_page_table_walk_core.sv =====
// Four-level x86-64 page table walker with an on-chip entry store.
// Input channel (in_valid / in_stall / in_data): a write transaction
//   (opcode 0) stores one 64-bit entry at byte address entry_address;
//   a translate transaction (opcode 1) walks PML4, PDPT, PD and PT for
//   virt_addr[47:0]. A nonzero table_base_override replaces the
//   configured base. Out-of-store reads return zero and fault the walk.
// Output channel (out_valid / out_stall / out_data): one transaction per
//   translate, physical_address plus fault; none for writes.
// Config channel (cfg_valid / cfg_ready / cfg_data): directory table base,
//   always ready; write only while the block is idle.
// Timing: a write is stored without leaving idle. A translate reads one
//   table level per walk state, since each entry address comes from the
//   entry before it through the single read port; no new transaction is
//   accepted until its result is loaded into the result register.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every
//   store entry with in_stall held high.
// Output stall: the result register holds; a new write transaction is
//   still accepted, a walk finishing meanwhile waits for the register.
module four_level_page_table_walk_core
  import ptw_pkg::*;
#(
  parameter int STORE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  ptw_cmd_t    cmd;
  ptw_status_t status;

  // sequencing: clearing pass, idle, one state per walked level
  ptw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // entry store, address formation, base register, result register
  ptw_datapath #(
    .STORE_ENTRIES (STORE_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
